// ----- hw/rtl/sdspc_pkg.sv -----
package sdspc_pkg;

  // symbols of the shuffle table and digits of a pin
  localparam int unsigned SYMBOL_COUNT = 10;
  localparam int unsigned PIN_DIGITS   = 4;

  // the request carries four digit fields
  localparam int unsigned FIELD_DIGITS = 4;
  localparam int unsigned USED_DIGITS  =
      (PIN_DIGITS < FIELD_DIGITS) ? PIN_DIGITS : FIELD_DIGITS;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned SEED_W  = 16;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned PIN_W   = 16;
  localparam int unsigned TRY_W   = 2;
  localparam int unsigned TAB_AW  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  // configuration port
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_OFFSET     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_MULTIPLIER = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STORED_PIN      = 8'd3;

  localparam logic [WORD_W-1:0] SEED_OFFSET_RST     = 32'h0088_1234;
  localparam logic [WORD_W-1:0] SEED_MULTIPLIER_RST = 32'h0000_3498;
  localparam logic [TRY_W-1:0]  MAX_TRIES_RST       = 2'd3;
  localparam logic [PIN_W-1:0]  STORED_PIN_RST      = 16'h0000;

  // decoded nibble for a digit code outside the table
  localparam logic [DIGIT_W-1:0] BAD_NIBBLE = 4'hF;

  typedef struct packed {
    logic [SEED_W-1:0]  session_seed;
    logic [DIGIT_W-1:0] digit_a;
    logic [DIGIT_W-1:0] digit_b;
    logic [DIGIT_W-1:0] digit_c;
    logic [DIGIT_W-1:0] digit_d;
  } in_t;

  typedef struct packed {
    logic             status_code;
    logic             lockout;
    logic [PIN_W-1:0] decoded_pin;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_MOD,
    ST_RDP,
    ST_WRI,
    ST_WRP,
    ST_DRD,
    ST_DCAP,
    ST_FIN
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_ADD,
    OP_MOD,
    OP_RDP,
    OP_WRI,
    OP_WRP,
    OP_DRD,
    OP_DCAP,
    OP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic last_step;
    logic last_byte;
    logic last_digit;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/seeded_digit_shuffle_pin_check.sv -----
// pin check with a seeded digit shuffle: each request brings a session seed and four
// scrambled digits. a 32-bit congruential sequence (x = offset + x * multiplier) run from
// the seed drives a fisher-yates shuffle of the digits 0..SYMBOL_COUNT-1, the received
// digits are decoded through the shuffled table and the result is compared with the
// stored pin; a wrong pin bumps a saturating 2-bit try counter that raises lockout once it
// reaches max_tries (zero turns lockout off), a right pin clears it. digit codes outside
// the table decode to nibble f and always count as wrong. one request is in work at a
// time; after acceptance every shuffle step passes through the shared 32x32 multiplier,
// the offset add, the byte-serial remainder over the four bytes of x and the table
// memory (read the partner entry, then one write per swapped entry through its single
// write port); each digit then needs a table read and a capture, and a final state loads
// the result register, after which the block goes idle before the next request is taken.
// a result still held by a stall delays that final load.
// the result sits in an output register, so a new request is taken as soon as the last
// result has been handed over or is still waiting there. configuration writes are
// always ready and must only be issued while the block is idle.
module seeded_digit_shuffle_pin_check
  import sdspc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  // sequencer: steps the shuffle, the decode and the result hand-off
  sdspc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: sequence state, remainder, table memory, try counter, result register
  sdspc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hw/rtl/sdspc_ram.sv -----
module sdspc_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 10
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/sdspc_ctrl.sv -----
module sdspc_ctrl
  import sdspc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_ADD;
      ST_ADD:  state_d = ST_MOD;
      ST_MOD: begin
        if (sts_i.last_byte) state_d = ST_RDP;
      end
      ST_RDP:  state_d = ST_WRI;
      ST_WRI:  state_d = ST_WRP;
      ST_WRP:  state_d = sts_i.last_step ? ST_DRD : ST_MUL;
      ST_DRD:  state_d = ST_DCAP;
      ST_DCAP: state_d = sts_i.last_digit ? ST_FIN : ST_DRD;
      ST_FIN: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = OP_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      ST_MUL:  cmd_o.op = OP_MUL;
      ST_ADD:  cmd_o.op = OP_ADD;
      ST_MOD:  cmd_o.op = OP_MOD;
      ST_RDP:  cmd_o.op = OP_RDP;
      ST_WRI:  cmd_o.op = OP_WRI;
      ST_WRP:  cmd_o.op = OP_WRP;
      ST_DRD:  cmd_o.op = OP_DRD;
      ST_DCAP: cmd_o.op = OP_DCAP;
      ST_FIN: begin
        if (sts_i.out_free) cmd_o.op = OP_FIN;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ----- hw/rtl/sdspc_dp.sv -----
module sdspc_dp
  import sdspc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  in_t                  in_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o
);

  localparam logic [TAB_AW-1:0] LAST_STEP  = TAB_AW'(SYMBOL_COUNT - 1);
  localparam logic [1:0]        LAST_DIGIT = 2'(USED_DIGITS - 1);

  // one byte of the remainder: v = r*256 + b stays below k*256
  function automatic logic [TAB_AW-1:0] rem_step(logic [TAB_AW-1:0] r, logic [7:0] b,
                                                 logic [TAB_AW:0] k);
    logic [TAB_AW+7:0] v;
    logic [TAB_AW+7:0] ks;
    v = {r, b};
    for (int j = 7; j >= 0; j--) begin
      ks = {k, 7'b0} >> (7 - j);
      if (v >= ks) v = v - ks;
    end
    return v[TAB_AW-1:0];
  endfunction

  // configuration
  logic [WORD_W-1:0] offset_q, mult_q;
  logic [TRY_W-1:0]  max_q;
  logic [PIN_W-1:0]  pin_q;

  // control state
  logic [TAB_AW-1:0]  i_q;
  logic [1:0]         byte_q;
  logic [1:0]         dc_q;
  logic [TRY_W-1:0]   wc_q;
  logic               out_valid_q;
  logic               valid_q [SYMBOL_COUNT];

  // payload
  logic [WORD_W-1:0]  x_q, prod_q;
  logic [TAB_AW-1:0]  r_q;
  logic [DIGIT_W-1:0] ti_q;
  logic [DIGIT_W-1:0] dig_q [FIELD_DIGITS];
  logic               dbad_q, bad_q;
  logic [PIN_W-1:0]   dec_q;
  logic               rd_hit_q;
  logic [TAB_AW-1:0]  rd_addr_q;
  out_t               out_q;

  // table memory
  logic               we;
  logic [TAB_AW-1:0]  waddr, raddr;
  logic [DIGIT_W-1:0] wdata, rdata, rd_val;

  logic [TAB_AW:0]    k;
  logic [7:0]         cur_byte;
  logic [DIGIT_W-1:0] cur_dig;
  logic               cur_bad;
  logic               match;
  logic [TRY_W-1:0]   wc_inc, wc_d;
  logic               lock;

  assign k        = (TAB_AW + 1)'(i_q) + (TAB_AW + 1)'(1);
  assign cur_byte = x_q[{~byte_q, 3'b000} +: 8];
  assign cur_dig  = dig_q[dc_q];
  assign cur_bad  = {1'b0, cur_dig} >= (DIGIT_W + 1)'(SYMBOL_COUNT);

  // entries never written still hold the identity
  assign rd_val = rd_hit_q ? rdata : DIGIT_W'(rd_addr_q);

  always_comb begin
    unique case (cmd_i.op)
      OP_MUL:  raddr = i_q;
      OP_RDP:  raddr = r_q;
      OP_DRD:  raddr = cur_bad ? '0 : cur_dig[TAB_AW-1:0];
      default: raddr = '0;
    endcase
  end

  assign we    = (cmd_i.op == OP_WRI) || (cmd_i.op == OP_WRP);
  assign waddr = (cmd_i.op == OP_WRI) ? i_q : r_q;
  assign wdata = (cmd_i.op == OP_WRI) ? rd_val : ti_q;

  sdspc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_tab (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // wrong-try bookkeeping
  assign match  = !bad_q && (dec_q == pin_q);
  assign wc_inc = (wc_q == '1) ? wc_q : wc_q + TRY_W'(1);
  always_comb begin
    wc_d = wc_q;
    lock = 1'b0;
    if (match) begin
      wc_d = '0;
    end else if (max_q != '0) begin
      wc_d = wc_inc;
      lock = wc_inc >= max_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= SEED_OFFSET_RST;
      mult_q      <= SEED_MULTIPLIER_RST;
      max_q       <= MAX_TRIES_RST;
      pin_q       <= STORED_PIN_RST;
      i_q         <= '0;
      byte_q      <= '0;
      dc_q        <= '0;
      wc_q        <= '0;
      out_valid_q <= 1'b0;
      for (int e = 0; e < SYMBOL_COUNT; e++) valid_q[e] <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SEED_OFFSET:     offset_q <= cfg_data_i;
          CFG_SEED_MULTIPLIER: mult_q   <= cfg_data_i;
          CFG_MAX_TRIES:       max_q    <= cfg_data_i[TRY_W-1:0];
          CFG_STORED_PIN:      pin_q    <= cfg_data_i[PIN_W-1:0];
          default: ;
        endcase
      end
      // a new result may replace one handed over at the same edge
      if (cmd_i.op == OP_FIN) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (we) valid_q[waddr] <= 1'b1;
      unique case (cmd_i.op)
        OP_LOAD: begin
          i_q  <= TAB_AW'(1);
          dc_q <= '0;
          for (int e = 0; e < SYMBOL_COUNT; e++) valid_q[e] <= 1'b0;
        end
        OP_ADD:  byte_q <= '0;
        OP_MOD:  byte_q <= byte_q + 2'd1;
        OP_WRP:  i_q <= i_q + TAB_AW'(1);
        OP_DCAP: dc_q <= dc_q + 2'd1;
        OP_FIN:  wc_q <= wc_d;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_hit_q  <= valid_q[raddr];
    rd_addr_q <= raddr;
    unique case (cmd_i.op)
      OP_LOAD: begin
        x_q      <= WORD_W'(in_data_i.session_seed);
        dig_q[0] <= in_data_i.digit_a;
        dig_q[1] <= in_data_i.digit_b;
        dig_q[2] <= in_data_i.digit_c;
        dig_q[3] <= in_data_i.digit_d;
        dec_q    <= '0;
        bad_q    <= 1'b0;
      end
      OP_MUL:  prod_q <= x_q * mult_q;
      OP_ADD: begin
        x_q  <= offset_q + prod_q;
        ti_q <= rd_val;
        r_q  <= '0;
      end
      OP_MOD:  r_q <= rem_step(r_q, cur_byte, k);
      OP_DRD:  dbad_q <= cur_bad;
      OP_DCAP: begin
        dec_q <= {dec_q[PIN_W-DIGIT_W-1:0], dbad_q ? BAD_NIBBLE : rd_val};
        bad_q <= bad_q | dbad_q;
      end
      OP_FIN: begin
        out_q.status_code <= !match;
        out_q.lockout     <= lock;
        out_q.decoded_pin <= dec_q;
      end
      default: ;
    endcase
  end

  assign sts_o.last_step  = (i_q == LAST_STEP);
  assign sts_o.last_byte  = (byte_q == 2'd3);
  assign sts_o.last_digit = (dc_q == LAST_DIGIT);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/sdspc_chk.sv -----
module sdspc_chk
  import sdspc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input in_t                  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input out_t                 out_data_o,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input logic [CFG_IDX_W-1:0] cfg_index_i,
  input logic [WORD_W-1:0]    cfg_data_i
);

  logic [PIN_W-1:0] dp;
  logic             bad_nib;

  assign dp = out_data_o.decoded_pin;
  assign bad_nib = ({1'b0, dp[3:0]}   >= (DIGIT_W + 1)'(SYMBOL_COUNT)) ||
                   ({1'b0, dp[7:4]}   >= (DIGIT_W + 1)'(SYMBOL_COUNT)) ||
                   ({1'b0, dp[11:8]}  >= (DIGIT_W + 1)'(SYMBOL_COUNT)) ||
                   ({1'b0, dp[15:12]} >= (DIGIT_W + 1)'(SYMBOL_COUNT));

  // a held result keeps its content
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a correct pin never comes with lockout
  a_match_no_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.status_code |-> !out_data_o.lockout)
    else $error("lockout on a correct pin");

  // an undecodable digit always reports a wrong pin
  a_bad_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_nib |-> out_data_o.status_code)
    else $error("bad digit reported as correct");

  // a request keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("new request taken right after acceptance");

  // configuration and request inputs are not otherwise checked here
  logic unused_ok;
  assign unused_ok = ^{in_data_i, cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i};

endmodule

bind seeded_digit_shuffle_pin_check sdspc_chk u_sdspc_chk (.*);

// ----- sim/seeded_digit_shuffle_pin_check_tb.sv -----
`timescale 1ns / 1ps

module seeded_digit_shuffle_pin_check_tb;
  import sdspc_pkg::*;

  // the drain is sized on the time one request takes in the block; the cycle limit is a fixed cap
  localparam int unsigned BLOCK_LATENCY = 91;
  localparam int unsigned DRAIN_CYCLES  = 2 * BLOCK_LATENCY + 20;
  localparam int unsigned LIMIT_CYCLES  = 1_500_000;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS   = 150;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_t                  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_t                 out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [WORD_W-1:0]    cfg_data_i  = '0;

  seeded_digit_shuffle_pin_check uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // our own copy of the block's registers and of its wrong-try counter
  logic [WORD_W-1:0] cur_offset     = SEED_OFFSET_RST;
  logic [WORD_W-1:0] cur_multiplier = SEED_MULTIPLIER_RST;
  logic [TRY_W-1:0]  cur_max_tries  = MAX_TRIES_RST;
  logic [PIN_W-1:0]  cur_pin        = STORED_PIN_RST;
  logic [TRY_W-1:0]  wrong_tries    = '0;

  // verdicts predicted for accepted requests, oldest first
  out_t expected_verdicts[$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // idling controls, changed by the test tasks
  bit          sender_idles = 1'b0;
  int unsigned burst_left   = 0;
  int unsigned stall_mode   = 0;
  int unsigned stall_run    = 0;
  bit          stalling     = 1'b0;

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // fisher-yates shuffle of the symbols driven by the congruential sequence;
  // the permutation comes back packed, entry n in nibble n
  function automatic logic [63:0] shuffle_symbols(input logic [SEED_W-1:0] seed);
    logic [63:0]       perm;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] p;
    logic [3:0]        held;
    int                i;
    for (i = 0; i < 16; i++) perm[i*4 +: 4] = 4'(i);
    x = WORD_W'(seed);
    for (i = 1; i < int'(SYMBOL_COUNT) && i < 16; i++) begin
      x = cur_offset + x * cur_multiplier;
      p = x % WORD_W'(i + 1);
      held = perm[i*4 +: 4];
      perm[i*4 +: 4] = perm[p[3:0]*4 +: 4];
      perm[p[3:0]*4 +: 4] = held;
    end
    return perm;
  endfunction

  // decode one attempt, compare with the stored pin and advance the try counter
  function automatic out_t judge_attempt(input in_t req);
    logic [63:0]      perm;
    logic [15:0]      codes;
    logic [3:0]       code;
    logic [PIN_W-1:0] decoded;
    logic [3:0]       nib;
    bit               bad_code;
    bit               hit;
    out_t             verdict;
    int               k;
    perm     = shuffle_symbols(req.session_seed);
    codes    = {req.digit_a, req.digit_b, req.digit_c, req.digit_d};
    decoded  = '0;
    bad_code = 1'b0;
    for (k = 0; k < int'(USED_DIGITS); k++) begin
      code = codes[15 - 4*k -: 4];
      if (code >= SYMBOL_COUNT) begin
        bad_code = 1'b1;
        nib = BAD_NIBBLE;
      end else begin
        nib = perm[code*4 +: 4];
      end
      decoded = {decoded[PIN_W-5:0], nib};
    end
    hit = !bad_code && decoded == cur_pin;
    verdict.status_code = !hit;
    verdict.lockout     = 1'b0;
    verdict.decoded_pin = decoded;
    if (hit) begin
      wrong_tries = '0;
    end else if (cur_max_tries != 0) begin
      // saturating count, lockout once it reaches the limit
      if (wrong_tries != 2'd3) wrong_tries = wrong_tries + 1'b1;
      verdict.lockout = wrong_tries >= cur_max_tries;
    end
    return verdict;
  endfunction

  // build the scrambled digits that decode to the given pin under the current
  // registers; nibbles the table cannot produce get a random code
  function automatic in_t scramble_pin(input logic [SEED_W-1:0] seed,
                                       input logic [PIN_W-1:0] pin);
    logic [63:0] perm;
    logic [15:0] codes;
    logic [3:0]  want;
    int          k;
    int          d;
    perm  = shuffle_symbols(seed);
    codes = '0;
    for (k = 0; k < int'(USED_DIGITS); k++) begin
      want = pin[4*(int'(USED_DIGITS) - 1 - k) +: 4];
      codes[15 - 4*k -: 4] = 4'($urandom_range(0, 15));
      for (d = 0; d < int'(SYMBOL_COUNT); d++) begin
        if (perm[d*4 +: 4] == want) codes[15 - 4*k -: 4] = 4'(d);
      end
    end
    return '{session_seed: seed, digit_a: codes[15:12], digit_b: codes[11:8],
             digit_c: codes[7:4], digit_d: codes[3:0]};
  endfunction

  function automatic in_t make_request(input logic [SEED_W-1:0] seed,
                                       input logic [3:0] a, input logic [3:0] b,
                                       input logic [3:0] c, input logic [3:0] d);
    return '{session_seed: seed, digit_a: a, digit_b: b, digit_c: c, digit_d: d};
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // present one request and hold it until the block takes it; valid stays high
  // so a burst runs back to back, a gap lowers it for a random number of cycles
  task automatic send_request(input in_t req);
    int unsigned gap;
    if (sender_idles && burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) gap = $urandom_range(0, 120);
      else gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    expected_verdicts.push_back(judge_attempt(req));
    if (burst_left != 0) burst_left--;
  endtask

  // stop sending and wait for every verdict to come back
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // register write; valid drops only after the last write of a batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value,
                           input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (last) cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SEED_OFFSET:     cur_offset     = value;
      CFG_SEED_MULTIPLIER: cur_multiplier = value;
      CFG_MAX_TRIES:       cur_max_tries  = value[TRY_W-1:0];
      CFG_STORED_PIN:      cur_pin        = value[PIN_W-1:0];
      default: ;  // unknown index, the block ignores it
    endcase
  endtask

  task automatic set_config(input logic [WORD_W-1:0] offset, input logic [WORD_W-1:0] mult,
                            input logic [TRY_W-1:0] tries, input logic [PIN_W-1:0] pin);
    write_reg(CFG_SEED_OFFSET, offset, 1'b0);
    write_reg(CFG_SEED_MULTIPLIER, mult, 1'b0);
    write_reg(CFG_MAX_TRIES, WORD_W'(tries), 1'b0);
    write_reg(CFG_STORED_PIN, WORD_W'(pin), 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // result side: stall pattern and comparison
  // --------------------------------------------------------------------------

  task automatic check_verdict(input out_t got);
    out_t want;
    if (expected_verdicts.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: status %0d lockout %0d pin %h",
                 got.status_code, got.lockout, got.decoded_pin);
    end else begin
      want = expected_verdicts.pop_front();
      if (got.status_code !== want.status_code || got.lockout !== want.lockout ||
          got.decoded_pin !== want.decoded_pin) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch: expected status %0d lockout %0d pin %h, got %0d %0d %h",
                   want.status_code, want.lockout, want.decoded_pin,
                   got.status_code, got.lockout, got.decoded_pin);
      end
    end
  endtask

  // outputs are read before this edge's updates land; stall is then set for
  // the next cycle: off, random single cycles, or long alternating runs
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_verdict(out_data_o);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_run == 0) begin
          stalling  = !stalling;
          stall_run = stalling ? $urandom_range(1, 40) : $urandom_range(1, 20);
        end
        stall_run--;
        out_stall_i <= stalling;
      end
    endcase
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("seeded_digit_shuffle_pin_check regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset registers: stored pin zero, lockout after three wrong tries
  task automatic test_reset_values();
    sender_idles = 1'b0;
    stall_mode   = 0;
    send_request(scramble_pin(16'h0000, cur_pin));
    send_request(scramble_pin(16'd65534, cur_pin));
    send_request(make_request(16'h2aaa, 4'd9, 4'd9, 4'd9, 4'd9));
  endtask

  // codes above nine decode to f and always count as wrong; drives the counter
  // into saturation with lockout at the reset limit
  task automatic test_invalid_digits();
    in_t req;
    stall_mode = 1;
    send_request(make_request(16'h5555, 4'd10, 4'd11, 4'd12, 4'd13));
    send_request(make_request(16'hffee, 4'd15, 4'd15, 4'd15, 4'd15));
    // right pin except one code out of range
    req = scramble_pin(16'h0f0f, cur_pin);
    req.digit_c = 4'd14;
    send_request(req);
  endtask

  // lockout limits one, zero (off) and two, each cleared by a right pin
  task automatic test_lockout();
    wait_drain();
    write_reg(CFG_MAX_TRIES, WORD_W'(2'd1), 1'b0);
    write_reg(CFG_STORED_PIN, 32'h0000_9999, 1'b1);
    send_request(make_request(16'h1234, 4'd0, 4'd1, 4'd2, 4'd3));
    send_request(scramble_pin(16'h4321, cur_pin));
    send_request(make_request(16'h0001, 4'd0, 4'd1, 4'd2, 4'd3));
    wait_drain();
    write_reg(CFG_MAX_TRIES, WORD_W'(2'd0), 1'b1);
    send_request(make_request(16'h8000, 4'd3, 4'd2, 4'd1, 4'd0));
    send_request(make_request(16'h7fff, 4'd3, 4'd2, 4'd1, 4'd0));
    send_request(scramble_pin(16'h00ff, cur_pin));
    wait_drain();
    write_reg(CFG_MAX_TRIES, WORD_W'(2'd2), 1'b1);
    send_request(make_request(16'h0101, 4'd0, 4'd1, 4'd2, 4'd3));
    send_request(make_request(16'h1010, 4'd0, 4'd1, 4'd2, 4'd3));
    send_request(scramble_pin(16'hc3c3, cur_pin));
  endtask

  // degenerate and all-ones sequence constants, plus writes to unknown indexes
  task automatic test_sequence_extremes();
    stall_mode = 2;
    wait_drain();
    set_config(32'h0000_0000, 32'h0000_0000, 2'd3, 16'h0000);
    send_request(scramble_pin(16'h3c3c, cur_pin));
    send_request(make_request(16'd65534, 4'd0, 4'd1, 4'd2, 4'd3));
    wait_drain();
    set_config(32'hffff_ffff, 32'hffff_ffff, 2'd3, 16'h1234);
    send_request(scramble_pin(16'h0000, cur_pin));
    send_request(make_request(16'h0000, 4'd9, 4'd8, 4'd7, 4'd6));
    wait_drain();
    write_reg(CFG_IDX_W'(4), 32'hdead_beef, 1'b0);
    write_reg('1, 32'h0000_0000, 1'b1);
    send_request(scramble_pin(16'h9abc, cur_pin));
  endtask

  // random phases: fresh registers per phase, mostly right pins and near misses
  // so the try counter keeps climbing and clearing, the rest plain noise
  task automatic test_random();
    logic [WORD_W-1:0] offset;
    logic [WORD_W-1:0] mult;
    logic [PIN_W-1:0]  pin;
    logic [SEED_W-1:0] seed;
    in_t               req;
    int unsigned       pick;
    int unsigned       phase;
    int unsigned       n;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drain();
      case ($urandom_range(0, 3))
        0: offset = '0;
        1: offset = '1;
        2: offset = SEED_OFFSET_RST;
        default: offset = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: mult = '0;
        1: mult = '1;
        2: mult = SEED_MULTIPLIER_RST;
        default: mult = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: pin = '0;
        1: pin = 16'h9999;
        2: pin = PIN_W'($urandom_range(0, 39321));
        default: pin = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                        4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      endcase
      set_config(offset, mult, TRY_W'($urandom_range(0, 3)), pin);
      // every pairing of sender idling and receiver stalls, first phase runs flat out
      stall_mode   = phase % 3;
      sender_idles = (phase % 2) != 0;
      burst_left   = 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        seed = SEED_W'($urandom_range(0, 65534));
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          req = scramble_pin(seed, cur_pin);
        end else if (pick < 55) begin
          // near miss: one code replaced
          req = scramble_pin(seed, cur_pin);
          case ($urandom_range(0, 3))
            0: req.digit_a = 4'($urandom_range(0, 15));
            1: req.digit_b = 4'($urandom_range(0, 15));
            2: req.digit_c = 4'($urandom_range(0, 15));
            default: req.digit_d = 4'($urandom_range(0, 15));
          endcase
        end else if (pick < 85) begin
          req = make_request(seed, 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                             4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)));
        end else begin
          req = make_request(seed, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                             4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        end
        send_request(req);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_invalid_digits();
    test_lockout();
    test_sequence_extremes();
    test_random();

    // let the last verdicts come home, then watch for strays
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_verdicts.size() == 0) begin
      $display("seeded_digit_shuffle_pin_check regression: pass");
    end else begin
      $display("seeded_digit_shuffle_pin_check regression: fail");
    end
    $finish;
  end

endmodule
